[src/sitda_pkg.sv]
// ----------------------------------------------------------------------------
// sitda_pkg: constants for the signed integer to decimal ASCII core
// Widths, character codes and the reciprocal used for the divide by ten.
// ----------------------------------------------------------------------------
package sitda_pkg;

    // Width of the incoming two's complement value.
    localparam int VALUE_W = 32;

    // Width of an ASCII character code on the result channel.
    localparam int CODE_W = 6;

    // Largest number of decimal digits in a 32-bit magnitude.
    localparam int MAX_DIGITS = 10;

    // Digit buffer index width.
    localparam int IDX_W = $clog2(MAX_DIGITS);

    // Character codes.
    localparam logic [CODE_W-1:0] CODE_MINUS = 6'd45;
    localparam logic [CODE_W-1:0] CODE_ZERO  = 6'd48;

    // ceil(2^35 / 10): floor(n * RECIP / 2^35) equals n / 10 for every 32-bit n.
    localparam logic [VALUE_W-1:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    // Width of the quotient of a 32-bit value by ten.
    localparam int QUOT_W = 2 * VALUE_W - RECIP_SHIFT;

endpackage

[src/signed_int_to_decimal_ascii_core.sv]
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal text
// Converts one 32-bit two's complement value into a run of ASCII characters.
// ----------------------------------------------------------------------------
//
// Usage. A request on the value channel (value_valid / value_ready) carries
// one 32-bit signed integer. The block answers with one request per character
// on the char channel (char_valid / char_ready), most significant first: a
// minus sign for negative values, then the digits without leading zeros. The
// final character of each number has last set. Zero gives a single '0'.
//
// Sequencing. value_ready is high only while the sequencer is
// idle. The magnitude is split into digits by one shared divide-by-ten unit
// (a reciprocal multiply and a subtract), with a multiply state and a
// remainder state per digit; the sign and the digits are then emitted.
// Characters leave at one per cycle while char_ready is high.
//
// Reset clears the sequencer and the output valid flag. When the receiver
// stalls, the character on the output is held and the sequencer waits. The
// final character may still wait in the output register while a new value
// is accepted.
//
module signed_int_to_decimal_ascii_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            value_valid,
    output logic                            value_ready,
    input  logic signed [sitda_pkg::VALUE_W-1:0] value,
    output logic                            char_valid,
    input  logic                            char_ready,
    output logic [sitda_pkg::CODE_W-1:0]    char_code,
    output logic                            last
);

    // Sequencer state codes.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_SIGN = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam int VW = sitda_pkg::VALUE_W;
    localparam int QW = sitda_pkg::QUOT_W;
    localparam int IW = sitda_pkg::IDX_W;

    logic [2:0]          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [VW-1:0]       mag_reg, mag_next;
    logic [2*VW-1:0]     prod_reg;
    logic [IW-1:0]       nd_reg, nd_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [3:0]          digit_mem [sitda_pkg::MAX_DIGITS];
    logic [3:0]          digit_rd_reg;
    logic                out_valid_reg, out_valid_next;
    logic [sitda_pkg::CODE_W-1:0] code_reg, code_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                load_ok;
    logic [QW-1:0]       quot;
    logic [VW-1:0]       quot_ext;
    logic [VW-1:0]       quot_x10;
    logic [VW-1:0]       rem_full;
    logic [3:0]          rem_digit;
    logic                digit_we;

    assign accept      = value_valid && value_ready;
    assign value_ready = (state_reg == S_IDLE);
    assign load_ok     = !out_valid_reg || char_ready;

    // Quotient and remainder of the magnitude by ten.
    assign quot      = prod_reg[2*VW-1:sitda_pkg::RECIP_SHIFT];
    assign quot_ext  = {{(VW-QW){1'b0}}, quot};
    assign quot_x10  = (quot_ext << 3) + (quot_ext << 1);
    assign rem_full  = mag_reg - quot_x10;
    assign rem_digit = rem_full[3:0];
    assign digit_we  = (state_reg == S_REM);

    // Sequencer and output register next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        nd_next        = nd_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !char_ready;
        code_next      = code_reg;
        last_next      = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = value[VW-1];
                    mag_next   = value[VW-1] ? (~value + 1'b1) : value;
                    nd_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                mag_next = quot_ext;
                nd_next  = nd_reg + 1'b1;
                if (quot == '0 || nd_reg == IW'(sitda_pkg::MAX_DIGITS - 1))
                begin
                    idx_next   = nd_reg;
                    state_next = neg_reg ? S_SIGN : S_EMIT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_SIGN:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    code_next      = sitda_pkg::CODE_MINUS;
                    last_next      = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    code_next      = sitda_pkg::CODE_ZERO + {2'b00, digit_rd_reg};
                    last_next      = (idx_reg == '0);
                    if (idx_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers; the shared multiplier result is registered here.
    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        nd_reg   <= nd_next;
        idx_reg  <= idx_next;
        code_reg <= code_next;
        last_reg <= last_next;
        prod_reg <= {{VW{1'b0}}, mag_reg} * {{VW{1'b0}}, sitda_pkg::RECIP10};
    end

    // Digit buffer, filled least significant first. The read port fetches the
    // digit for the next emit index, so it is ready when the sequencer needs
    // it; a digit written on the same edge is passed straight through.
    always_ff @(posedge clk)
    begin
        if (digit_we)
        begin
            digit_mem[nd_reg] <= rem_digit;
        end
        if (digit_we && (nd_reg == idx_next))
        begin
            digit_rd_reg <= rem_digit;
        end
        else
        begin
            digit_rd_reg <= digit_mem[idx_next];
        end
    end

    assign char_valid = out_valid_reg;
    assign char_code  = code_reg;
    assign last       = last_reg;

    // A minus sign is never the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_code == sitda_pkg::CODE_MINUS) |-> !last)
        else $error("minus sign flagged as last character");

    // The emit pointer always lies inside the collected digits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (idx_reg < nd_reg))
        else $error("emit index beyond collected digits");

    // The remainder step always follows a multiply step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> ($past(state_reg) == S_MUL))
        else $error("remainder step without preceding multiply");

    // A remainder never reaches ten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> (rem_full < 32'd10))
        else $error("divide by ten produced a bad remainder");

    // Once a request is taken the block is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !value_ready)
        else $error("value accepted while block stays ready");

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: signed integer to decimal ASCII core
// Drives 32-bit signed values into the core and checks every character that
// comes back, sign and last flag included, against a predicted text built
// from the unsigned magnitude. The sender works in bursts, and the receiver
// stalls in changing patterns, with two long hold-offs that back up the core.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF      = 6;
    localparam int RANDOM_ITEMS  = 360;
    localparam int HOLD_CYCLES   = 250;
    localparam int HOLD_SPACING  = 200;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;

    // One expected character on the result channel.
    typedef struct packed {
        logic [sitda_pkg::CODE_W-1:0] code;
        logic                         last;
    } text_char_t;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_EVERY_THIRD,
        RX_SPARSE
    } rx_mode_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 value_valid = 1'b0;
    logic                                 value_ready;
    logic signed [sitda_pkg::VALUE_W-1:0] value = '0;
    logic                                 char_valid;
    logic                                 char_ready = 1'b0;
    logic [sitda_pkg::CODE_W-1:0]         char_code;
    logic                                 last;

    logic signed [sitda_pkg::VALUE_W-1:0] pending_values[$];
    text_char_t                           expected_text[$];

    logic     value_taken = 1'b0;
    int       values_accepted = 0;
    int       error_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       hold_left = 0;
    int       hold_mark = 60;
    int       mode_left = 0;
    int       phase_count = 0;
    rx_mode_t rx_mode = RX_ALWAYS;

    signed_int_to_decimal_ascii_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_code   (char_code),
        .last        (last)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Prints one line per mismatch and keeps the tally.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Appends the decimal text of v to the expected characters: a minus sign
    // for negative values, then the digits of the unsigned magnitude.
    task automatic predict_text(input logic signed [sitda_pkg::VALUE_W-1:0] v);
        logic [sitda_pkg::VALUE_W-1:0] magnitude;
        logic [3:0]                    digits [sitda_pkg::MAX_DIGITS];
        int                            n_digits;
        text_char_t                    c;
        magnitude = v[sitda_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
        digits[0] = 4'(magnitude % 32'd10);
        magnitude = magnitude / 32'd10;
        n_digits  = 1;
        while (magnitude != 0)
        begin
            digits[n_digits] = 4'(magnitude % 32'd10);
            magnitude = magnitude / 32'd10;
            n_digits++;
        end
        if (v[sitda_pkg::VALUE_W-1])
        begin
            c.code = sitda_pkg::CODE_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        for (int i = n_digits - 1; i >= 0; i--)
        begin
            c.code = sitda_pkg::CODE_ZERO + {2'b00, digits[i]};
            c.last = (i == 0);
            expected_text.push_back(c);
        end
    endtask

    // Mostly values of a chosen digit count with either sign, so that every
    // text length turns up often; the rest are raw 32-bit words.
    function automatic logic signed [sitda_pkg::VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        int     n_digits;
        logic [sitda_pkg::VALUE_W-1:0] magnitude;
        if ($urandom_range(3, 0) == 0)
            return $urandom;
        n_digits = $urandom_range(sitda_pkg::MAX_DIGITS, 1);
        lo = 1;
        for (int i = 1; i < n_digits; i++)
            lo = lo * 10;
        hi = lo * 10 - 1;
        if (hi > 2147483647)
            hi = 2147483647;
        if (n_digits == 1)
            lo = 0;
        magnitude = $urandom_range(32'(hi), 32'(lo));
        if ($urandom_range(1, 0) == 1)
            return -$signed(magnitude);
        return $signed(magnitude);
    endfunction

    // Sender: offers the pending values in bursts with random gaps between.
    always @(negedge clk)
    begin
        if (!rst_n)
            value_valid <= 1'b0;
        else if (value_valid && !value_taken)
        begin
            // Request still waiting: hold it unchanged.
        end
        else if (gap_left > 0)
        begin
            value_valid <= 1'b0;
            gap_left    <= gap_left - 1;
        end
        else if (pending_values.size() == 0)
            value_valid <= 1'b0;
        else
        begin
            value       <= pending_values.pop_front();
            value_valid <= 1'b1;
            if (burst_left <= 1)
            begin
                burst_left <= $urandom_range(12, 1);
                gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(20, 1);
            end
            else
                burst_left <= burst_left - 1;
        end
    end

    // Receiver: switches between stall patterns, and twice holds off for a
    // long stretch so that the core fills and refuses new values.
    always @(negedge clk)
    begin
        if (!rst_n)
            char_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            char_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end
        else if (values_accepted >= hold_mark)
        begin
            char_ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_mark  <= hold_mark + HOLD_SPACING;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(3, 0));
                mode_left <= $urandom_range(100, 20);
            end
            else
                mode_left <= mode_left - 1;
            phase_count <= phase_count + 1;
            case (rx_mode)
                RX_ALWAYS:      char_ready <= 1'b1;
                RX_MOSTLY:      char_ready <= ($urandom_range(9, 0) < 7);
                RX_EVERY_THIRD: char_ready <= (phase_count % 3 == 0);
                default:        char_ready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // Monitor: predicts on each accepted value and checks each character.
    always @(posedge clk)
    begin
        text_char_t want;
        value_taken <= value_valid && value_ready;
        if (rst_n)
        begin
            if (value_valid && value_ready)
            begin
                predict_text(value);
                values_accepted <= values_accepted + 1;
            end
            if (char_valid && char_ready)
            begin
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected character %0d last %0b",
                                              char_code, last));
                else
                begin
                    want = expected_text.pop_front();
                    if (char_code !== want.code)
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  char_code, want.code));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b on code %0d",
                                                  last, want.last, want.code));
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((value_valid && value_ready) || (char_valid && char_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no progress for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        // Corner values: zero, single digits, powers of ten and their
        // neighbours, both extremes and alternating bit patterns.
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'sd9);
        pending_values.push_back(-32'sd9);
        pending_values.push_back(32'sd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'sd99);
        pending_values.push_back(32'sd100);
        pending_values.push_back(32'sd12345);
        pending_values.push_back(32'sd999999999);
        pending_values.push_back(-32'sd999999999);
        pending_values.push_back(32'sd1000000000);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'sd1000000001);
        pending_values.push_back(32'sh7FFF_FFFF);
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(32'sh8000_0001);
        pending_values.push_back(32'sh5555_5555);
        pending_values.push_back(32'shAAAA_AAAA);
        pending_values.push_back(32'sd0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending_values.push_back(random_value());

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || value_valid)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
src/sitda_pkg.sv
src/signed_int_to_decimal_ascii_core.sv
tb/testbench.sv
